[design/dpft_pkg.sv]
// Shared constants and types for the demand paging FIFO translator.
// Used by demand_paging_fifo_translator and the testbench; depends on nothing.

package dpft_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MaxPagesDef  = 256;
  localparam int unsigned MaxFramesDef = 64;
  localparam int unsigned AddrBitsDef  = 32;

  // Fixed field widths.
  localparam int unsigned PagesW   = 9;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned FramesW  = 7;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PhysW    = 32;
  localparam int unsigned CountW   = 32;

  // Configuration reset values.
  localparam logic [PagesW-1:0]  PagesRst  = 9'd256;
  localparam logic [ShiftW-1:0]  ShiftRst  = 5'd12;
  localparam logic [FramesW-1:0] FramesRst = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPages  = 2'd0,
    CfgShift  = 2'd1,
    CfgFrames = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatusHit   = 2'd0,
    StatusFault = 2'd1,
    StatusRange = 2'd2
  } status_e;

endpackage

[design/dpft_ram.sv]
// Simple one-write, one-read memory with registered, write-first read data.
// Generic; used by demand_paging_fifo_translator for the frame table and the FIFO ring.

module dpft_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A write to the address being read shows up in the read data right away.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/demand_paging_fifo_translator.sv]
// Top level of the demand paging translator with FIFO page replacement.
// Depends on dpft_pkg and dpft_ram.
//
// Usage:
// - An address transfer happens at a rising edge with start high and busy low.
//   busy is always low: a new address may be given in every cycle.
// - Each address gives one result after the resolve stage and the result
//   registers; done_o is high for exactly one cycle, with phys_addr_o, status_o,
//   invalidate_valid_o, flush_frame_o, hit_total_o and fault_total_o valid. The
//   receiver cannot hold results off, so no result ever waits.
// - Throughput is one address per cycle. The registered read of the page-to-frame
//   table and of the FIFO ring head comes first; the resolve stage then decides
//   hit, fault or eviction and writes the tables. Writes of one address reach
//   the reads of the next through bypass paths.
// - Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
//   no address is in flight; unknown indexes are ignored.
// - Reset clears the valid bits, the ring pointers and both counters and loads
//   the default configuration; it takes effect at once, with no clearing pass.

module demand_paging_fifo_translator #(
  parameter int unsigned MAX_PAGES  = dpft_pkg::MaxPagesDef,
  parameter int unsigned MAX_FRAMES = dpft_pkg::MaxFramesDef,
  parameter int unsigned ADDR_BITS  = dpft_pkg::AddrBitsDef,
  localparam int unsigned FRAME_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [dpft_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dpft_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [ADDR_BITS-1:0]          virtual_address_i,
  output logic                          done_o,
  output logic [dpft_pkg::PhysW-1:0]    phys_addr_o,
  output logic [1:0]                    status_o,
  output logic                          invalidate_valid_o,
  output logic [FRAME_W-1:0]            flush_frame_o,
  output logic [dpft_pkg::CountW-1:0]   hit_total_o,
  output logic [dpft_pkg::CountW-1:0]   fault_total_o
);

  localparam int unsigned PAGE_W  = $clog2(MAX_PAGES);
  localparam int unsigned FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_A   = (ADDR_BITS > PAGE_W + 1) ? ADDR_BITS : PAGE_W + 1;
  localparam int unsigned CMP_W   = (CMP_A > dpft_pkg::PagesW) ? CMP_A : dpft_pkg::PagesW;
  localparam int unsigned FCMP_W  = (FCNT_W > dpft_pkg::FramesW) ? FCNT_W : dpft_pkg::FramesW;
  localparam int unsigned VAEXT_W = (ADDR_BITS > dpft_pkg::PhysW) ? ADDR_BITS : dpft_pkg::PhysW;
  localparam int unsigned RING_DW = PAGE_W + FRAME_W;
  localparam int unsigned SUM_W   = FCNT_W + 1;

  // Configuration registers.
  logic [dpft_pkg::PagesW-1:0]  pages_q;
  logic [dpft_pkg::ShiftW-1:0]  shift_q;
  logic [dpft_pkg::FramesW-1:0] frames_q;

  // Resolve stage and table state.
  logic                         s1_vld_q;
  logic [ADDR_BITS-1:0]         va_q;
  logic [MAX_PAGES-1:0]         entry_valid_q, entry_valid_d;
  logic [FRAME_W-1:0]           head_q, head_d, head_inc;
  logic [FCNT_W-1:0]            count_q, count_d;
  logic [dpft_pkg::CountW-1:0]  hit_cnt_q, hit_cnt_d;
  logic [dpft_pkg::CountW-1:0]  fault_cnt_q, fault_cnt_d;

  // Result registers.
  logic                         done_q;
  logic [dpft_pkg::PhysW-1:0]   phys_q;
  dpft_pkg::status_e            status_q;
  logic                         inv_vld_q;
  logic [FRAME_W-1:0]           inv_frame_q;

  // Combinational resolve signals.
  logic                         accept;
  logic [ADDR_BITS-1:0]         rd_page_full;
  logic [PAGE_W-1:0]            rd_page;
  logic [ADDR_BITS-1:0]         page_full;
  logic [PAGE_W-1:0]            page;
  logic [CMP_W-1:0]             pages_ext, npages;
  logic [FCMP_W-1:0]            frames_ext, nframes;
  logic                         in_range, hit, fault, evict;
  logic [FRAME_W-1:0]           table_frame;
  logic [RING_DW-1:0]           ring_rdata, ring_wdata;
  logic [PAGE_W-1:0]            victim_page;
  logic [FRAME_W-1:0]           victim_frame;
  logic [FRAME_W-1:0]           frame_sel;
  logic [FCNT_W-1:0]            base_cnt;
  logic [FRAME_W-1:0]           base_head;
  logic [SUM_W-1:0]             wpos_sum;
  logic [FRAME_W-1:0]           ring_waddr;
  logic                         tbl_we;
  logic [VAEXT_W-1:0]           va_ext;
  logic [dpft_pkg::PhysW-1:0]   offset_mask, phys_d;
  dpft_pkg::status_e            status_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q  <= dpft_pkg::PagesRst;
      shift_q  <= dpft_pkg::ShiftRst;
      frames_q <= dpft_pkg::FramesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpft_pkg::CfgPages:  pages_q  <= cfg_wdata_i[dpft_pkg::PagesW-1:0];
        dpft_pkg::CfgShift:  shift_q  <= cfg_wdata_i[dpft_pkg::ShiftW-1:0];
        dpft_pkg::CfgFrames: frames_q <= cfg_wdata_i[dpft_pkg::FramesW-1:0];
        default: ;
      endcase
    end
  end

  // The frame table is read with the incoming address so that the data is
  // ready when the address reaches the resolve stage.
  assign rd_page_full = virtual_address_i >> shift_q;
  assign rd_page      = rd_page_full[PAGE_W-1:0];

  dpft_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (FRAME_W)
  ) u_frame_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (page),
    .wdata_i (frame_sel),
    .raddr_i (rd_page),
    .rdata_o (table_frame)
  );

  // The ring is read at the head that holds after this edge, so the oldest
  // resident page is always at hand.
  dpft_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (RING_DW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (head_d),
    .rdata_o (ring_rdata)
  );

  assign victim_page  = ring_rdata[RING_DW-1:FRAME_W];
  assign victim_frame = ring_rdata[FRAME_W-1:0];

  always_comb begin
    page_full  = va_q >> shift_q;
    page       = page_full[PAGE_W-1:0];
    pages_ext  = CMP_W'(pages_q);
    npages     = (pages_ext > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : pages_ext;
    in_range   = CMP_W'(page_full) < npages;
    frames_ext = FCMP_W'(frames_q);
    nframes    = (frames_ext > FCMP_W'(MAX_FRAMES)) ? FCMP_W'(MAX_FRAMES) : frames_ext;
    if (nframes == '0) begin
      nframes = FCMP_W'(1);
    end

    hit   = in_range && entry_valid_q[page];
    fault = in_range && !entry_valid_q[page];
    evict = fault && (FCMP_W'(count_q) >= nframes);

    head_inc = (head_q == FRAME_W'(MAX_FRAMES - 1)) ? '0 : head_q + FRAME_W'(1);

    if (hit) begin
      frame_sel = table_frame;
    end else if (evict) begin
      frame_sel = victim_frame;
    end else begin
      frame_sel = FRAME_W'(count_q);
    end

    // New page goes in behind the last resident one.
    base_head = evict ? head_inc : head_q;
    base_cnt  = evict ? count_q - FCNT_W'(1) : count_q;
    wpos_sum  = SUM_W'(base_head) + SUM_W'(base_cnt);
    if (wpos_sum >= SUM_W'(MAX_FRAMES)) begin
      wpos_sum = wpos_sum - SUM_W'(MAX_FRAMES);
    end
    ring_waddr = wpos_sum[FRAME_W-1:0];
    ring_wdata = {page, frame_sel};

    tbl_we  = s1_vld_q && fault;
    head_d  = (s1_vld_q && evict) ? head_inc : head_q;
    count_d = (s1_vld_q && fault && !evict) ? count_q + FCNT_W'(1) : count_q;

    entry_valid_d = entry_valid_q;
    if (tbl_we) begin
      // The victim is resident and the new page is not, so they differ.
      if (evict) begin
        entry_valid_d[victim_page] = 1'b0;
      end
      entry_valid_d[page] = 1'b1;
    end

    hit_cnt_d = hit_cnt_q;
    if (s1_vld_q && hit && (hit_cnt_q != '1)) begin
      hit_cnt_d = hit_cnt_q + dpft_pkg::CountW'(1);
    end
    fault_cnt_d = fault_cnt_q;
    if (s1_vld_q && fault && (fault_cnt_q != '1)) begin
      fault_cnt_d = fault_cnt_q + dpft_pkg::CountW'(1);
    end

    va_ext      = VAEXT_W'(va_q);
    offset_mask = (dpft_pkg::PhysW'(1) << shift_q) - dpft_pkg::PhysW'(1);
    if (in_range) begin
      phys_d = (dpft_pkg::PhysW'(frame_sel) << shift_q)
             | (va_ext[dpft_pkg::PhysW-1:0] & offset_mask);
    end else begin
      phys_d = '0;
    end

    if (!in_range) begin
      status_d = dpft_pkg::StatusRange;
    end else if (hit) begin
      status_d = dpft_pkg::StatusHit;
    end else begin
      status_d = dpft_pkg::StatusFault;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q      <= 1'b0;
      done_q        <= 1'b0;
      entry_valid_q <= '0;
      head_q        <= '0;
      count_q       <= '0;
      hit_cnt_q     <= '0;
      fault_cnt_q   <= '0;
    end else begin
      s1_vld_q      <= accept;
      done_q        <= s1_vld_q;
      entry_valid_q <= entry_valid_d;
      head_q        <= head_d;
      count_q       <= count_d;
      hit_cnt_q     <= hit_cnt_d;
      fault_cnt_q   <= fault_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q <= virtual_address_i;
    end
    if (s1_vld_q) begin
      phys_q      <= phys_d;
      status_q    <= status_d;
      inv_vld_q   <= evict;
      inv_frame_q <= evict ? victim_frame : '0;
    end
  end

  // The counters already hold the totals after the access being reported.
  assign done_o             = done_q;
  assign phys_addr_o        = phys_q;
  assign status_o           = status_q;
  assign invalidate_valid_o = inv_vld_q;
  assign flush_frame_o      = inv_frame_q;
  assign hit_total_o        = hit_cnt_q;
  assign fault_total_o      = fault_cnt_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("transfer accepted without a result two cycles later");

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FCNT_W'(MAX_FRAMES))
    else $error("ring count exceeds the number of frames");

  a_inv_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalidate_valid_o) |-> (status_o == dpft_pkg::StatusFault))
    else $error("invalidation reported without a page fault");

  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == dpft_pkg::StatusRange))
      |-> ((phys_addr_o == '0) && !invalidate_valid_o))
    else $error("out-of-range result carries an address or invalidation");

endmodule

[tb/sv/page_translation_checker.sv]
// Checker for the demand paging FIFO translator: predicts each translation and compares it.
// Watches the address, configuration and result ports of the block; depends on dpft_pkg.

module page_translation_checker
  import dpft_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [31:0]         virtual_address_i,
  input  logic                done_o,
  input  logic [PhysW-1:0]    phys_addr_o,
  input  logic [1:0]          status_o,
  input  logic                invalidate_valid_o,
  input  logic [5:0]          flush_frame_o,
  input  logic [CountW-1:0]   hit_total_o,
  input  logic [CountW-1:0]   fault_total_o,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PhysW-1:0]  phys;
    status_e           status;
    logic              inv_valid;
    logic [5:0]        inv_frame;
    logic [CountW-1:0] hits;
    logic [CountW-1:0] faults;
  } translation_t;

  // Own copy of the configuration and of the page table state.
  logic [PagesW-1:0]  pages_cfg;
  logic [ShiftW-1:0]  shift_cfg;
  logic [FramesW-1:0] frames_cfg;
  logic               page_valid [MaxPagesDef];
  logic [5:0]         page_frame [MaxPagesDef];
  logic [7:0]         resident_fifo [MaxFramesDef];
  logic [5:0]         fifo_head;
  logic [6:0]         fifo_count;
  logic [CountW-1:0]  hit_cnt;
  logic [CountW-1:0]  fault_cnt;

  translation_t expected_translations[$];
  translation_t oldest;

  function automatic translation_t translate_address(input logic [31:0] va);
    translation_t res;
    logic [63:0]  page;
    logic [63:0]  offset;
    logic [63:0]  phys;
    int unsigned  npages;
    int unsigned  nframes;
    logic [7:0]   p;
    logic [7:0]   victim;
    logic [5:0]   frame_no;
    logic [5:0]   slot;
    res = '0;
    res.status = StatusRange;
    page = {32'b0, va} >> shift_cfg;
    offset = {32'b0, va} & ((64'd1 << shift_cfg) - 64'd1);
    npages = (pages_cfg > MaxPagesDef) ? MaxPagesDef : pages_cfg;
    nframes = (frames_cfg > MaxFramesDef) ? MaxFramesDef : frames_cfg;
    if (nframes == 0) nframes = 1;
    if (page < npages) begin
      p = page[7:0];
      if (page_valid[p]) begin
        if (hit_cnt != '1) hit_cnt++;
        res.status = StatusHit;
      end else begin
        if (fault_cnt != '1) fault_cnt++;
        res.status = StatusFault;
        if (fifo_count < nframes) begin
          frame_no = fifo_count[5:0];
        end else begin
          // No free frame: the oldest resident page gives up its frame.
          victim = resident_fifo[fifo_head];
          fifo_head = fifo_head + 6'd1;
          fifo_count = fifo_count - 7'd1;
          frame_no = page_frame[victim];
          page_valid[victim] = 1'b0;
          res.inv_valid = 1'b1;
          res.inv_frame = frame_no;
        end
        page_valid[p] = 1'b1;
        page_frame[p] = frame_no;
        slot = fifo_head + fifo_count[5:0];
        resident_fifo[slot] = p;
        fifo_count = fifo_count + 7'd1;
      end
      phys = ({58'b0, page_frame[p]} << shift_cfg) + offset;
      res.phys = phys[31:0];
    end
    res.hits = hit_cnt;
    res.faults = fault_cnt;
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_cfg = PagesRst;
      shift_cfg = ShiftRst;
      frames_cfg = FramesRst;
      for (int i = 0; i < MaxPagesDef; i++) begin
        page_valid[i] = 1'b0;
        page_frame[i] = '0;
      end
      fifo_head = '0;
      fifo_count = '0;
      hit_cnt = '0;
      fault_cnt = '0;
      expected_translations.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (done_o) begin
        if (expected_translations.size() == 0) begin
          $display("%0t: result with no translation pending: actual phys 0x%0h status %0d",
                   $time, phys_addr_o, status_o);
          fail_count_o++;
        end else begin
          oldest = expected_translations.pop_front();
          compare_field("phys_addr", oldest.phys, phys_addr_o);
          compare_field("status", 32'(oldest.status), 32'(status_o));
          compare_field("invalidate_valid", 32'(oldest.inv_valid), 32'(invalidate_valid_o));
          compare_field("flush_frame", 32'(oldest.inv_frame), 32'(flush_frame_o));
          compare_field("hit_total", oldest.hits, hit_total_o);
          compare_field("fault_total", oldest.faults, fault_total_o);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPages) pages_cfg = cfg_wdata_i[PagesW-1:0];
        else if (cfg_idx_i == CfgShift) shift_cfg = cfg_wdata_i[ShiftW-1:0];
        else if (cfg_idx_i == CfgFrames) frames_cfg = cfg_wdata_i[FramesW-1:0];
      end
      if (start && !busy) expected_translations.push_back(translate_address(virtual_address_i));
      pending_o = expected_translations.size();
    end
  end

endmodule

[tb/sv/demand_paging_fifo_translator_test.sv]
// Top of the translator testbench: clock, reset, address and register stimulus, verdict.
// Depends on dpft_pkg, demand_paging_fifo_translator and page_translation_checker.

module demand_paging_fifo_translator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dpft_pkg::*;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned RandomPerPhase = 160;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic [31:0]         virtual_address_i;
  logic                done_o;
  logic [PhysW-1:0]    phys_addr_o;
  logic [1:0]          status_o;
  logic                invalidate_valid_o;
  logic [5:0]          flush_frame_o;
  logic [CountW-1:0]   hit_total_o;
  logic [CountW-1:0]   fault_total_o;
  int unsigned         fail_count;
  int unsigned         pending;

  // Register values as last written, used to aim addresses at mapped pages.
  int unsigned cur_pages;
  int unsigned cur_shift;
  int unsigned cur_frames;

  demand_paging_fifo_translator uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .virtual_address_i  (virtual_address_i),
    .done_o             (done_o),
    .phys_addr_o        (phys_addr_o),
    .status_o           (status_o),
    .invalidate_valid_o (invalidate_valid_o),
    .flush_frame_o      (flush_frame_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

  page_translation_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .virtual_address_i  (virtual_address_i),
    .done_o             (done_o),
    .phys_addr_o        (phys_addr_o),
    .status_o           (status_o),
    .invalidate_valid_o (invalidate_valid_o),
    .flush_frame_o      (flush_frame_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Every call starts and ends at a falling edge; start stays high for the next transfer.
  task automatic send_address(input logic [31:0] va, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    virtual_address_i <= va;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off new transfers until every pending translation has come back.
  task automatic drain();
    start <= 1'b0;
    wait (pending == 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Unused upper data bits are filled at random; the block must mask them.
  task automatic configure(input int unsigned pages, input int unsigned shift,
                           input int unsigned frames);
    drain();
    write_reg(CfgPages, pages[PagesW-1:0]);
    write_reg(CfgShift, {4'($urandom()), shift[ShiftW-1:0]});
    write_reg(CfgFrames, {2'($urandom()), frames[FramesW-1:0]});
    cur_pages = pages;
    cur_shift = shift;
    cur_frames = frames;
  endtask

  // Mostly pages in a working set a little larger than the frame count, so that
  // hits, faults and evictions all occur; the rest lands just past the mapped
  // range or anywhere at all.
  function automatic logic [31:0] pick_address();
    int unsigned kind;
    int unsigned span;
    int unsigned npages;
    int unsigned nframes;
    logic [31:0] page;
    logic [31:0] offset_mask;
    npages = (cur_pages > MaxPagesDef) ? MaxPagesDef : cur_pages;
    nframes = (cur_frames > MaxFramesDef) ? MaxFramesDef : cur_frames;
    if (nframes == 0) nframes = 1;
    kind = $urandom_range(0, 99);
    if (kind < 12 || npages == 0) return $urandom();
    if (kind < 20) begin
      page = npages + $urandom_range(0, 3);
    end else begin
      span = nframes + nframes / 2 + 2;
      if (span > npages) span = npages;
      page = $urandom_range(0, span - 1);
    end
    offset_mask = (32'd1 << cur_shift) - 32'd1;
    return (page << cur_shift) | ($urandom() & offset_mask);
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned idle_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i < count / 3) idle_pct = 37;
      else if (i < 2 * count / 3) idle_pct = 59;
      else idle_pct = 0;
      send_address(pick_address(), idle_pct);
    end
  endtask

  logic [31:0] default_vas [8] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0FFF, 32'hFFFF_FFFF,
    32'h000F_F123, 32'h0010_0000, 32'h8000_0000, 32'h000F_F000
  };
  // Four 16-byte pages in two frames: fill, evict three times, run off the end, evict again.
  logic [31:0] small_vas [7] = '{
    32'h0000_0000, 32'h0000_0015, 32'h0000_002F, 32'h0000_0005,
    32'h0000_003F, 32'h0000_0040, 32'h0000_0015
  };
  // Frame count lowered below the resident count.
  logic [31:0] shrunk_vas [4] = '{
    32'h0000_0025, 32'h0000_0037, 32'h0000_0025, 32'h0000_0001
  };

  int unsigned phase_pages  [12] = '{256, 256, 16,  1, 0, 511, 300, 64, 64, 200, 257, 8};
  int unsigned phase_shift  [12] = '{ 12,   0,  4, 20, 12,  8,  31,  6,  6,  21,   2, 3};
  int unsigned phase_frames [12] = '{ 64,  64,  4,  1, 8, 127,   0, 64,  3,  33,  65, 16};

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgPages;
    cfg_wdata_i = '0;
    virtual_address_i = '0;
    cur_pages = PagesRst;
    cur_shift = ShiftRst;
    cur_frames = FramesRst;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (default_vas[i]) send_address(default_vas[i], 0);
    configure(4, 4, 2);
    foreach (small_vas[i]) send_address(small_vas[i], 0);
    drain();
    write_reg(CfgFrames, 9'd1);
    cur_frames = 1;
    foreach (shrunk_vas[i]) send_address(shrunk_vas[i], 0);
    drain();
    write_reg(CfgSpare, 9'h1FF);
    send_address(32'h0000_0037, 0);

    foreach (phase_pages[i]) begin
      configure(phase_pages[i], phase_shift[i], phase_frames[i]);
      run_random(RandomPerPhase);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
